@@ sv/hpe_pkg.sv @@
// Shared widths, types and constants for the Hermite polynomial evaluator.
package hpe_pkg;

   localparam int WORD_W     = 64;
   localparam int MAX_DEGREE = 1023;
   localparam int DEGREE_W   = $clog2(MAX_DEGREE + 1);
   localparam int BIT_CNT_W  = $clog2(WORD_W);

   typedef logic [WORD_W-1:0]   word_type;
   typedef logic [DEGREE_W-1:0] degree_type;

   // status of the shared modular multiplier
   typedef struct packed {
      logic busy;
      logic done;
   } mm_stat_type;

endpackage

@@ sv/hpe_mulmod.sv @@
// Bit-serial modular multiplier: acc = a * b mod m, one bit of b per cycle.
module hpe_mulmod (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  hpe_pkg::word_type   a,
   input  hpe_pkg::word_type   b,
   input  hpe_pkg::word_type   m,
   output hpe_pkg::mm_stat_type stat,
   output hpe_pkg::word_type   result
);
   import hpe_pkg::*;

   word_type               acc_ff, acc_in;
   word_type               a_ff, a_in;
   word_type               b_ff, b_in;
   logic [BIT_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                   run_ff, run_in;
   logic                   done_ff, done_in;

   logic [WORD_W:0] dbl_sum, dbl_red, add_sum, add_red;
   word_type        dbl_mod;

   // double, then add a when the current bit of b is set; both reduced by one subtract
   always_comb begin
      dbl_sum = {acc_ff, 1'b0};
      dbl_red = (dbl_sum >= {1'b0, m}) ? dbl_sum - {1'b0, m} : dbl_sum;
      dbl_mod = dbl_red[WORD_W-1:0];
      add_sum = {1'b0, dbl_mod} + {1'b0, a_ff};
      add_red = (add_sum >= {1'b0, m}) ? add_sum - {1'b0, m} : add_sum;
   end

   always_comb begin
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in = '0;
         a_in   = a;
         b_in   = b;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         acc_in = b_ff[WORD_W-1] ? add_red[WORD_W-1:0] : dbl_mod;
         b_in   = {b_ff[WORD_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == BIT_CNT_W'(WORD_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign stat.busy = run_ff;
   assign stat.done = done_ff;
   assign result    = acc_ff;

endmodule

@@ sv/hermite_poly_eval_mod_unit.sv @@
// Top level: probabilists' Hermite polynomial He_n(point) mod m by recurrence.
module hermite_poly_eval_mod_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  hpe_pkg::degree_type  req_degree,
   input  hpe_pkg::word_type    req_point,
   output logic                 rsp_valid,
   output hpe_pkg::word_type    rsp_value_out,
   input  logic                 csr_we,
   input  hpe_pkg::word_type    csr_wdata
);
   // A transaction is taken when start is high and busy is low; its result
   // appears on rsp_value_out for exactly one cycle with rsp_valid, and the
   // receiver must take it then, as nothing holds it. Every product goes
   // through one shared bit-serial modular multiplier, so a transaction
   // first reduces the point and then runs two products per recurrence
   // step up to degree n. Busy stays high throughout the transaction. The
   // modulus register is written through csr_we and csr_wdata; the user must
   // write it only while busy is low, as the block does not enforce this.
   // A written zero acts as a modulus of one.
   import hpe_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_REDUCE = 3'd1;
   localparam logic [2:0] ST_CHECK  = 3'd2;
   localparam logic [2:0] ST_MUL1   = 3'd3;
   localparam logic [2:0] ST_MUL2   = 3'd4;

   logic [2:0]  state_ff, state_in;
   word_type    modulus_ff, modulus_in;
   degree_type  n_ff, n_in;
   degree_type  kcnt_ff, kcnt_in;
   word_type    kmod_ff, kmod_in;
   word_type    x_ff, x_in;
   word_type    prev_ff, prev_in;
   word_type    cur_ff, cur_in;
   word_type    xb_ff, xb_in;
   logic        valid_ff, valid_in;
   word_type    value_ff, value_in;

   logic        mm_start;
   word_type    mm_a, mm_b, mm_result;
   mm_stat_type mm_stat;

   word_type        one_mod, diff, kmod_next;
   logic [WORD_W:0] kmod_sum;

   hpe_mulmod u_mulmod (
      .clock  (clock),
      .reset  (reset),
      .start  (mm_start),
      .a      (mm_a),
      .b      (mm_b),
      .m      (modulus_ff),
      .stat   (mm_stat),
      .result (mm_result)
   );

   // 1 mod m, next k mod m, and x*He_k - k*He_{k-1} mod m
   always_comb begin
      one_mod   = (modulus_ff == WORD_W'(1)) ? '0 : WORD_W'(1);
      kmod_sum  = {1'b0, kmod_ff} + 1'b1;
      kmod_next = (kmod_sum == {1'b0, modulus_ff}) ? '0 : kmod_sum[WORD_W-1:0];
      diff      = (xb_ff >= mm_result) ? xb_ff - mm_result
                                       : xb_ff + (modulus_ff - mm_result);
   end

   // modulus register: a zero write stands for one
   always_comb begin
      modulus_in = modulus_ff;
      if (csr_we) begin
         modulus_in = (csr_wdata == '0) ? WORD_W'(1) : csr_wdata;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      n_in     = n_ff;
      kcnt_in  = kcnt_ff;
      kmod_in  = kmod_ff;
      x_in     = x_ff;
      prev_in  = prev_ff;
      cur_in   = cur_ff;
      xb_in    = xb_ff;
      valid_in = 1'b0;
      value_in = value_ff;
      mm_start = 1'b0;
      mm_a     = x_ff;
      mm_b     = cur_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               // reduce the point as 1 * point mod m
               n_in     = req_degree;
               mm_start = 1'b1;
               mm_a     = WORD_W'(1);
               mm_b     = req_point;
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (mm_stat.done) begin
               x_in     = mm_result;
               cur_in   = mm_result;
               prev_in  = one_mod;
               kmod_in  = one_mod;
               kcnt_in  = DEGREE_W'(1);
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            priority if (n_ff == '0) begin
               valid_in = 1'b1;
               value_in = one_mod;
               state_in = ST_IDLE;
            end else if (kcnt_ff == n_ff) begin
               valid_in = 1'b1;
               value_in = cur_ff;
               state_in = ST_IDLE;
            end else begin
               mm_start = 1'b1;
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            if (mm_stat.done) begin
               // hold x*He_k and start k*He_{k-1}
               xb_in    = mm_result;
               mm_start = 1'b1;
               mm_a     = kmod_ff;
               mm_b     = prev_ff;
               state_in = ST_MUL2;
            end
         end
         ST_MUL2: begin
            if (mm_stat.done) begin
               // advance the recurrence one step
               prev_in  = cur_ff;
               cur_in   = diff;
               kmod_in  = kmod_next;
               kcnt_in  = kcnt_ff + 1'b1;
               state_in = ST_CHECK;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      kcnt_ff  <= kcnt_in;
      kmod_ff  <= kmod_in;
      x_ff     <= x_in;
      prev_ff  <= prev_in;
      cur_ff   <= cur_in;
      xb_ff    <= xb_in;
      value_ff <= value_in;
      if (reset) begin
         state_ff   <= ST_IDLE;
         valid_ff   <= 1'b0;
         modulus_ff <= WORD_W'(1);
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         modulus_ff <= modulus_in;
      end
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = valid_ff;
   assign rsp_value_out = value_ff;

   // a result only leaves once the sequencer is back at rest
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == ST_IDLE))
      else $error("result strobe outside idle");

   // results always lie below the modulus
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_value_out < modulus_ff))
      else $error("result not reduced");

   // an accepted transaction always begins with the point reduction
   a_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == ST_REDUCE))
      else $error("accepted transaction did not start reduction");

   // the multiplier is never restarted mid-product
   a_mm_start: assert property (@(posedge clock) disable iff (reset)
      mm_start |-> !mm_stat.busy)
      else $error("multiplier restarted while running");

   // a product only completes while the sequencer waits for one
   a_mm_done: assert property (@(posedge clock) disable iff (reset)
      mm_stat.done |-> (state_ff == ST_REDUCE || state_ff == ST_MUL1 ||
                        state_ff == ST_MUL2))
      else $error("unexpected product completion");

endmodule

@@ test/hermite_poly_eval_mod_unit_test.sv @@
// Self-checking testbench for the Hermite polynomial evaluator, modulo a configured modulus.
`timescale 1ns / 100ps

module hermite_poly_eval_mod_unit_test;
   import hpe_pkg::*;

   localparam int    CLK_HALF     = 6;
   localparam longint LIMIT_NS    = 64'd600_000_000;
   localparam word_type PRIME_TOP = 64'hFFFF_FFFF_FFFF_FFC5;  // largest 64-bit prime
   localparam word_type BIT_TOP   = 64'h8000_0000_0000_0000;
   localparam int    MAX_REPORTS  = 10;
   localparam int    IDLE_PCT     = 12;

   // one evaluation request: degree and point
   typedef struct {
      degree_type degree;
      word_type   point;
   } eval_req_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       start      = 1'b0;
   logic       busy;
   degree_type req_degree = '0;
   word_type   req_point  = '0;
   logic       rsp_valid;
   word_type   rsp_value_out;
   logic       csr_we     = 1'b0;
   word_type   csr_wdata  = '0;

   eval_req_type pending_reqs[$];   // transactions not yet taken by the block
   word_type   expected_values[$];  // predicted results, oldest first
   word_type   shadow_modulus;      // our copy of the modulus register
   word_type   want_value;
   logic       took_req   = 1'b0;   // a transaction was taken at the last rising edge
   logic       steady     = 1'b0;   // suppress sender gaps for one phase
   int         mismatch_count = 0;

   hermite_poly_eval_mod_unit DUT (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_degree    (req_degree),
      .req_point     (req_point),
      .rsp_valid     (rsp_valid),
      .rsp_value_out (rsp_value_out),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // He_n(pt) mod m by the three-term recurrence, using 128-bit products.
   // A modulus of zero behaves as one.
   function automatic word_type hermite_mod(degree_type n, word_type pt, word_type modv);
      logic [127:0] m, x, prev, cur, xb, ka, nxt;
      int k;
      m    = (modv == '0) ? 128'd1 : {64'd0, modv};
      x    = {64'd0, pt} % m;
      prev = 128'd1 % m;
      cur  = x;
      if (n == '0)
         return prev[63:0];
      for (k = 1; k < int'(n); k++) begin
         xb  = (x * cur) % m;
         ka  = ((128'(k) % m) * prev) % m;
         nxt = (xb >= ka) ? (xb - ka) : (xb + (m - ka));
         prev = cur;
         cur  = nxt;
      end
      return cur[63:0];
   endfunction

   // Rising edge: mirror register writes, predict each taken transaction and
   // check each result strobe against the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         shadow_modulus = 64'd1;
         took_req <= 1'b0;
      end else begin
         took_req <= start && !busy;
         if (csr_we)
            shadow_modulus = csr_wdata;
         if (start && !busy)
            expected_values.insert(expected_values.size(),
                                   hermite_mod(req_degree, req_point, shadow_modulus));
         if (rsp_valid) begin
            if (expected_values.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("unexpected result: value_out %h", rsp_value_out);
            end else begin
               want_value = expected_values.pop_front();
               if (rsp_value_out !== want_value) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display("value_out mismatch: expected %h, got %h",
                              want_value, rsp_value_out);
               end
            end
         end
      end
   end

   // Falling edge: retire the transaction taken at the last rising edge, then
   // present the next one unless this cycle is picked as a gap.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (took_req)
            void'(pending_reqs.pop_front());
         if (pending_reqs.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
            start      <= 1'b1;
            req_degree <= pending_reqs[0].degree;
            req_point  <= pending_reqs[0].point;
         end else begin
            start <= 1'b0;
         end
      end
   end

   task automatic queue_req(input degree_type n, input word_type pt);
      eval_req_type r;
      r.degree = n;
      r.point  = pt;
      pending_reqs.insert(pending_reqs.size(), r);
   endtask

   // Random transactions: mostly low degrees to keep the run short, with a
   // sprinkling of high ones and the maximum; points mix corner values, values around the modulus and random ones.
   task automatic queue_random(input int count, input word_type modv);
      degree_type n;
      word_type   pt;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(99)) inside
            [0:59]:  n = degree_type'($urandom_range(15));
            [60:87]: n = degree_type'($urandom_range(127, 16));
            [88:96]: n = degree_type'($urandom_range(MAX_DEGREE - 1, 128));
            default: n = degree_type'(MAX_DEGREE);
         endcase
         case ($urandom_range(7))
            0:       pt = '0;
            1:       pt = '1;
            2:       pt = modv - 64'd1;
            3:       pt = modv;
            4:       pt = modv + 64'($urandom_range(5));
            5:       pt = 64'($urandom_range(100));
            default: pt = {$urandom, $urandom};
         endcase
         queue_req(n, pt);
      end
   endtask

   // Hold until every transaction is taken and answered and the block is idle.
   task automatic settle();
      while (pending_reqs.size() != 0 || expected_values.size() != 0 || busy)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_modulus(input word_type value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Stimulus: directed corners first, then random phases over several moduli.
   initial begin
      word_type phase_mods[9];
      phase_mods[0] = 64'd1;
      phase_mods[1] = 64'd2;
      phase_mods[2] = 64'd97;
      phase_mods[3] = '1;
      phase_mods[4] = BIT_TOP;
      phase_mods[5] = 64'h0000_0001_0000_000F;
      phase_mods[6] = {$urandom, $urandom};
      phase_mods[7] = 64'($urandom_range(1 << 20, 3));
      phase_mods[8] = PRIME_TOP;

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // modulus left at its reset value of one: every result is zero
      queue_req(degree_type'(0), '1);
      queue_req(degree_type'(1), '1);
      queue_req(degree_type'(MAX_DEGREE), '1);
      queue_random(6, 64'd1);
      settle();

      // a written zero acts as modulus one
      write_modulus('0);
      queue_req(degree_type'(0), '0);
      queue_req(degree_type'(MAX_DEGREE), 64'h0123_4567_89AB_CDEF);
      queue_req(degree_type'(5), '1);
      queue_random(6, '0);
      settle();

      // large prime modulus: degrees zero and one, points at and just below m, then higher degrees
      write_modulus(PRIME_TOP);
      queue_req(degree_type'(0), '0);
      queue_req(degree_type'(0), '1);
      queue_req(degree_type'(1), '0);
      queue_req(degree_type'(1), '1);
      queue_req(degree_type'(1), PRIME_TOP);
      queue_req(degree_type'(1), PRIME_TOP - 64'd1);
      queue_req(degree_type'(2), '1);
      queue_req(degree_type'(2), PRIME_TOP - 64'd1);
      queue_req(degree_type'(3), 64'd5);
      queue_req(degree_type'(10), 64'd2);
      queue_req(degree_type'(MAX_DEGREE), '1);
      queue_req(degree_type'(MAX_DEGREE), PRIME_TOP - 64'd1);
      queue_req(degree_type'(512), BIT_TOP);
      queue_req(degree_type'(MAX_DEGREE - 1), {$urandom, $urandom});
      settle();

      // random phases; one of them runs without sender gaps
      for (int p = 0; p < 9; p++) begin
         write_modulus(phase_mods[p]);
         steady = (p == 2);
         queue_random(29, phase_mods[p]);
         settle();
      end
      steady = 1'b0;

      repeat (16) @(negedge clock);
      if (mismatch_count == 0 && expected_values.size() == 0) begin
         $display("[hermite_poly_eval_mod_unit] OK");
      end else begin
         $display("[hermite_poly_eval_mod_unit] ERROR");
      end
      $finish;
   end

   // Abandon a hung run.
   initial begin
      #(LIMIT_NS);
      $display("[hermite_poly_eval_mod_unit] ERROR");
      $finish;
   end

endmodule
